// ----- rtl/wsht_pkg.sv -----
// Shared types and constants for the window stack hit test block.
// No dependencies.
`default_nettype none
package wsht_pkg;
  typedef enum logic [2:0] {
    KIND_PLACE = 3'd0,
    KIND_MOVE  = 3'd1,
    KIND_SETPOS = 3'd2,
    KIND_HIDE  = 3'd3,
    KIND_GETPOS = 3'd4,
    KIND_HIT   = 3'd5
  } kind_code_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [6:0] POS_NONE = 7'h7f;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  lyr_id;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [11:0] win_width;
    logic [11:0] win_height;
    logic [6:0]  stack_pos;
    logic [5:0]  skip_id;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position_found;
    logic [5:0] hit_layer;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/wsht_front.sv -----
// Front part: two-entry queue of accepted items.
// Depends on wsht_pkg.
`default_nettype none
module wsht_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire wsht_pkg::item_t item_i,
  output logic                 valid_o,
  input  wire logic            take_i,
  output wsht_pkg::item_t      item_o
);
  import wsht_pkg::*;

  item_t      q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = q_mem[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("front queue count out of range");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> full_o) else $error("queue lost an item");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !do_push) |=> !valid_o) else $error("phantom item");
`endif
endmodule
`default_nettype wire

// ----- rtl/wsht_back.sv -----
// Back part: geometry table, z-order stack memory and the slot-walking sequencer.
// Depends on wsht_pkg.
`default_nettype none
module wsht_back #(
  parameter int MaxLayers = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire wsht_pkg::item_t item_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output wsht_pkg::result_t    res_o,
  input  wire logic            res_pop_i
);
  import wsht_pkg::*;

  localparam int SW = $clog2(MaxLayers);
  localparam int CW = $clog2(MaxLayers + 1);
  localparam logic [CW-1:0] MAXC = CW'(MaxLayers);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FREAD, S_REM, S_REMW, S_INS, S_INSW, S_MWR,
    S_HREAD, S_HCHK, S_HCMP, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_GETPOS, OP_HIDE, OP_SETPOS
  } op_e;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } geo_t;

  localparam result_t RES_OK = '{status: ST_OK, position_found: '0, hit_layer: '0};
  localparam result_t RES_UNKNOWN = '{status: ST_UNKNOWN, position_found: '0, hit_layer: '0};
  localparam result_t RES_ABSENT = '{status: ST_OK, position_found: POS_NONE, hit_layer: '0};

  state_e state_q;
  item_t  it_q;
  op_e    op_q;
  logic [CW-1:0] cnt_q, idx_q, ins_q;
  logic [SW-1:0] raddr;
  logic [5:0] rdata_q;
  logic [5:0] zmem [MaxLayers];
  logic       zwe;
  logic [SW-1:0] zwa;
  logic [5:0] zwd;
  geo_t       gmem [64];
  geo_t       gread_q;
  logic [5:0] graddr;
  logic       gwe;
  logic [5:0] gwa;
  geo_t       gwd;
  logic [63:0] hasw_q;
  result_t res_q;
  logic    rv_q;
  logic [5:0]  hid;
  logic signed [17:0] px, py, x0, y0, x1, y1;
  logic inside_pt;

  assign res_valid_o = rv_q;
  assign res_o = res_q;
  assign take_o = (state_q == S_IDLE) && valid_i && !rv_q;

  // The hit test and the insert walk read the slot just below the index.
  assign raddr = (state_q == S_HREAD || state_q == S_INS) ? SW'(idx_q - CW'(1))
                                                          : idx_q[SW-1:0];

  always_ff @(posedge clk_i) begin
    rdata_q <= zmem[raddr];
    if (zwe) zmem[zwa] <= zwd;
  end

  // Place writes at dispatch; a move reads the old entry at dispatch and writes it
  // back, with the offset added, in the next cycle (S_MWR).
  always_comb begin
    graddr = rdata_q;
    if (state_q == S_IDLE) graddr = item_i.lyr_id;
  end

  always_comb begin
    gwe = 1'b0;
    gwa = it_q.lyr_id;
    gwd = gread_q;
    if (take_o && item_i.kind == KIND_PLACE && item_i.lyr_id != 6'd0) begin
      gwe = 1'b1;
      gwa = item_i.lyr_id;
      gwd = '{x: item_i.x_coord, y: item_i.y_coord, w: item_i.win_width,
              h: item_i.win_height};
    end else if (state_q == S_MWR) begin
      gwe = 1'b1;
      gwd.x = gread_q.x + it_q.x_coord;
      gwd.y = gread_q.y + it_q.y_coord;
    end
  end

  always_ff @(posedge clk_i) begin
    gread_q <= gmem[graddr];
    if (gwe) gmem[gwa] <= gwd;
  end

  // The slot is read again while its geometry is fetched, so rdata_q still holds it.
  assign hid = rdata_q;
  assign px = 18'(signed'(it_q.x_coord));
  assign py = 18'(signed'(it_q.y_coord));
  assign x0 = 18'(signed'(gread_q.x));
  assign y0 = 18'(signed'(gread_q.y));
  assign x1 = x0 + 18'(gread_q.w);
  assign y1 = y0 + 18'(gread_q.h);
  assign inside_pt = (x0 <= px) && (px < x1) && (y0 <= py) && (py < y1);

  always_comb begin
    zwe = 1'b0;
    zwa = idx_q[SW-1:0];
    zwd = rdata_q;
    if (state_q == S_REMW) begin
      zwe = 1'b1;
      zwa = SW'(idx_q - CW'(1));
    end else if (state_q == S_INSW) begin
      zwe = 1'b1;
      zwa = idx_q[SW-1:0];
    end else if (state_q == S_INS && idx_q == ins_q) begin
      zwe = 1'b1;
      zwa = idx_q[SW-1:0];
      zwd = it_q.lyr_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hasw_q <= '0;
      cnt_q <= '0;
      rv_q <= 1'b0;
      idx_q <= '0;
      ins_q <= '0;
      op_q <= OP_GETPOS;
      it_q <= '0;
      res_q <= '0;
    end else begin
      if (rv_q && res_pop_i) rv_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (take_o) begin
            it_q <= item_i;
            idx_q <= (item_i.kind == KIND_HIT) ? cnt_q : '0;
            unique case (item_i.kind)
              KIND_PLACE: begin
                res_q <= (item_i.lyr_id == 6'd0) ? RES_UNKNOWN : RES_OK;
                if (item_i.lyr_id != 6'd0) hasw_q[item_i.lyr_id] <= 1'b1;
                state_q <= S_DONE;
              end
              KIND_MOVE: begin
                if (item_i.lyr_id == 6'd0 || !hasw_q[item_i.lyr_id]) begin
                  res_q <= RES_UNKNOWN;
                  state_q <= S_DONE;
                end else begin
                  res_q <= RES_OK;
                  state_q <= S_MWR;
                end
              end
              KIND_SETPOS, KIND_HIDE: begin
                op_q <= (item_i.kind == KIND_HIDE || item_i.stack_pos[6]) ? OP_HIDE
                                                                          : OP_SETPOS;
                if (item_i.lyr_id == 6'd0 || !hasw_q[item_i.lyr_id]) begin
                  res_q <= RES_UNKNOWN;
                  state_q <= S_DONE;
                end else begin
                  res_q <= RES_OK;
                  state_q <= (cnt_q == '0) ? S_FREAD : S_FIND;
                end
              end
              KIND_GETPOS: begin
                op_q <= OP_GETPOS;
                res_q <= RES_ABSENT;
                state_q <= (item_i.lyr_id == 6'd0 || cnt_q == '0) ? S_DONE : S_FIND;
              end
              KIND_HIT: begin
                res_q <= RES_OK;
                state_q <= (cnt_q == '0) ? S_DONE : S_HREAD;
              end
              default: begin
                res_q <= RES_OK;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        // Read slot idx, then compare in S_FREAD.
        S_FIND: state_q <= S_FREAD;
        S_FREAD: begin
          if (cnt_q != '0 && rdata_q == it_q.lyr_id && idx_q < cnt_q) begin
            if (op_q == OP_GETPOS) begin
              res_q.position_found <= 7'(idx_q);
              state_q <= S_DONE;
            end else begin
              // Remove: shift upper slots down by one.
              idx_q <= idx_q + CW'(1);
              state_q <= S_REM;
            end
          end else if (cnt_q != '0 && idx_q + CW'(1) < cnt_q) begin
            idx_q <= idx_q + CW'(1);
            state_q <= S_FIND;
          end else begin
            // Not stacked.
            if (op_q == OP_SETPOS) begin
              if (cnt_q == MAXC) begin
                res_q.status <= ST_FULL;
                state_q <= S_DONE;
              end else begin
                ins_q <= (CW'(it_q.stack_pos[5:0]) > cnt_q) ? cnt_q
                                                           : CW'(it_q.stack_pos[5:0]);
                idx_q <= cnt_q;
                state_q <= S_INS;
              end
            end else state_q <= S_DONE;
          end
        end
        S_REM: begin
          if (idx_q < cnt_q) state_q <= S_REMW;
          else begin
            cnt_q <= cnt_q - CW'(1);
            if (op_q == OP_SETPOS) begin
              ins_q <= (CW'(it_q.stack_pos[5:0]) > cnt_q - CW'(1)) ? cnt_q - CW'(1)
                                                                  : CW'(it_q.stack_pos[5:0]);
              idx_q <= cnt_q - CW'(1);
              state_q <= S_INS;
            end else state_q <= S_DONE;
          end
        end
        S_REMW: begin
          idx_q <= idx_q + CW'(1);
          state_q <= S_REM;
        end
        // Insert: walk from the top, copying slot idx-1 to idx, until ins.
        S_INS: begin
          if (idx_q == ins_q) begin
            cnt_q <= cnt_q + CW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_INSW;
          end
        end
        S_INSW: begin
          idx_q <= idx_q - CW'(1);
          state_q <= S_INS;
        end
        S_MWR: state_q <= S_DONE;
        S_HREAD: begin
          idx_q <= idx_q - CW'(1);
          state_q <= S_HCHK;
        end
        S_HCHK: state_q <= S_HCMP;
        S_HCMP: begin
          if (hid != it_q.skip_id && hasw_q[hid] && inside_pt) begin
            res_q.hit_layer <= hid;
            state_q <= S_DONE;
          end else if (idx_q == '0) state_q <= S_DONE;
          else state_q <= S_HREAD;
        end
        S_DONE: begin
          if (!rv_q) begin
            rv_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAXC) else $error("stack count exceeds depth");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> state_q != S_IDLE) else $error("dispatch did not start work");
  a_done_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !rv_q) |=> rv_q) else $error("result not posted");
`endif
endmodule
`default_nettype wire

// ----- rtl/window_stack_hit_test.sv -----
// Window z-order stack with hit test: top level joining the front queue and back sequencer.
// Depends on wsht_pkg, wsht_front and wsht_back.
//
// Usage: items enter through push/full; an item is taken on a clock edge with
// push high and full low. Two items may wait in the front queue while the back
// part works. Results leave through empty/pop; the oldest result is on the
// result ports while empty is low and leaves on an edge with pop high.
// Each item gives one result. Get position reads the stack one slot at a time. Hide
// and set position walk to the layer and shift the upper slots down; set position
// then opens the new slot. Hit test reads the stack top down, each slot taking a
// slot read, a geometry read and a compare. Items are handled one at a time: the
// back part takes the next waiting item in the cycle after the previous result is
// popped, so while a result is not popped the front queue keeps accepting until it
// is full.
// Reset clears the has-window bits and the stack count; no clearing pass is run.
`default_nettype none
module window_stack_hit_test #(
  parameter int MAX_LAYERS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  kind_i,
  input  wire logic [5:0]  lyr_id_i,
  input  wire logic [15:0] x_coord_i,
  input  wire logic [15:0] y_coord_i,
  input  wire logic [11:0] win_width_i,
  input  wire logic [11:0] win_height_i,
  input  wire logic [6:0]  stack_pos_i,
  input  wire logic [5:0]  skip_id_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status_o,
  output logic [6:0]       position_found_o,
  output logic [5:0]       hit_layer_o
);
  import wsht_pkg::*;

  item_t   in_item, q_item;
  logic    q_valid, q_take, rv;
  result_t res;

  assign in_item = '{kind: kind_i, lyr_id: lyr_id_i, x_coord: x_coord_i,
                     y_coord: y_coord_i, win_width: win_width_i,
                     win_height: win_height_i, stack_pos: stack_pos_i,
                     skip_id: skip_id_i};

  wsht_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  wsht_back #(.MaxLayers(MAX_LAYERS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(q_item), .take_o(q_take),
    .res_valid_o(rv), .res_o(res), .res_pop_i(pop)
  );

  assign empty = !rv;
  assign status_o = res.status;
  assign position_found_o = res.position_found;
  assign hit_layer_o = res.hit_layer;
endmodule
`default_nettype wire
